@@ rtl/stle_pkg.sv @@
// Shared types and constants for the session table with oldest-entry eviction.
package stle_pkg;

    // Slot index and entry count widths, wide enough for a table of 256 slots
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int ID_W   = 64;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 5;
    localparam int SLOT_W = 4;

    // Item actions
    localparam logic ACT_CREATE = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // Search record handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [IDX_W-1:0]  best_idx;
        logic [TIME_W-1:0] best_time;
    } t_probe;

    // Item context broadcast to every cell during a scan
    typedef struct packed {
        logic              action;
        logic [ID_W-1:0]   key;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  lim;
    } t_ctl;

    // Entry write broadcast; the cell whose index matches takes it
    typedef struct packed {
        logic              en;
        logic              id_en;
        logic [IDX_W-1:0]  slot;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
    } t_wr;

    // One result word
    typedef struct packed {
        logic              matched;
        logic [IDX_W-1:0]  slot;
        logic              replaced;
    } t_res;

endpackage

@@ rtl/stle_cell.sv @@
// One table slot: holds an entry and updates the passing search record.
module stle_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stle_pkg::t_ctl   i_ctl,
    input  stle_pkg::t_wr    i_wr,
    input  stle_pkg::t_probe i_probe,
    output stle_pkg::t_probe o_probe
);

    logic [stle_pkg::ID_W-1:0]   r_id;
    logic [stle_pkg::TIME_W-1:0] r_time;
    stle_pkg::t_probe            r_probe;
    stle_pkg::t_probe            n_probe;
    logic                        live;
    logic                        in_lim;

    assign live   = stle_pkg::CNT_W'(IDX) < i_ctl.count;
    assign in_lim = stle_pkg::CNT_W'(IDX) < i_ctl.lim;

    // Fold this slot into the search record
    always_comb begin
        n_probe = i_probe;
        if (i_probe.valid) begin
            if (i_ctl.action == stle_pkg::ACT_LOOKUP) begin
                if (!i_probe.hit && live && (r_id == i_ctl.key)) begin
                    n_probe.hit     = 1'b1;
                    n_probe.hit_idx = stle_pkg::IDX_W'(IDX);
                end
            end else begin
                if (in_lim && ((IDX == 0) || (r_time < i_probe.best_time))) begin
                    n_probe.best_idx  = stle_pkg::IDX_W'(IDX);
                    n_probe.best_time = r_time;
                end
            end
        end
    end

    // Advance the search record to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    // Take an entry write addressed to this slot
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.slot == stle_pkg::IDX_W'(IDX))) begin
            if (i_wr.id_en) begin
                r_id <= i_wr.id;
            end
            r_time <= i_wr.stamp;
        end
    end

    assign o_probe = r_probe;

endmodule

@@ rtl/session_table_lru_evict.sv @@
// Top level: session table with lookup and oldest-timestamp eviction.
//
//  channel | direction | handshake                   | word
//  --------+-----------+-----------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall     | action, session_id, now
//  out     | output    | o_out_valid / i_out_stall   | matched, slot, replaced_oldest
//  cfg     | input     | i_cfg_valid / o_cfg_ready   | session limit
//
//  A create that appends writes its slot straight from the idle state; a lookup or an
//  evicting create sends a search record along the row of cells, one cell per cycle.
//  One item is in work at a time; the next is taken once the result is in the
//  output register, which may still be waiting for the receiver.
//  Synchronous reset empties the table and sets the session limit to 16.
//  A stalled result holds in the output register; the following item waits in
//  the finish state until the register frees.
module session_table_lru_evict #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [stle_pkg::ID_W-1:0]     i_session_id,
    input  logic [stle_pkg::TIME_W-1:0]   i_now,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_matched,
    output logic [stle_pkg::SLOT_W-1:0]   o_slot,
    output logic                          o_replaced_oldest,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [stle_pkg::CFG_W-1:0]    i_cfg_data
);

    stle_pkg::t_state              r_state, n_state;
    logic [stle_pkg::CFG_W-1:0]    r_max;
    logic [stle_pkg::CNT_W-1:0]    r_count, n_count;
    logic [stle_pkg::CNT_W-1:0]    lim;
    logic [stle_pkg::CNT_W-1:0]    max_ext;
    logic                          r_action;
    logic [stle_pkg::ID_W-1:0]     r_key;
    logic [stle_pkg::TIME_W-1:0]   r_now;
    logic                          r_start, n_start;
    stle_pkg::t_res                r_res, n_res;
    stle_pkg::t_res                r_out;
    logic                          r_out_valid;
    logic                          out_load;
    logic                          in_acc;
    logic                          out_take;
    stle_pkg::t_ctl                ctl;
    stle_pkg::t_wr                 wr;
    stle_pkg::t_probe              chain [MAX_ENTRIES+1];

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Clamp the configured maximum to 1..MAX_ENTRIES
    assign max_ext = stle_pkg::CNT_W'(r_max);
    always_comb begin
        lim = max_ext;
        if (max_ext == '0) begin
            lim = stle_pkg::CNT_W'(1);
        end
        if (max_ext > stle_pkg::CNT_W'(MAX_ENTRIES)) begin
            lim = stle_pkg::CNT_W'(MAX_ENTRIES);
        end
    end

    // Next state, entry writes and result
    always_comb begin
        n_state    = r_state;
        n_start    = 1'b0;
        n_count    = r_count;
        n_res      = r_res;
        out_load   = 1'b0;
        wr         = '0;
        o_in_stall = (r_state != stle_pkg::S_IDLE);
        case (r_state)
            stle_pkg::S_IDLE: begin
                if (in_acc) begin
                    if ((i_action == stle_pkg::ACT_CREATE) && (r_count < lim)) begin
                        wr.en    = 1'b1;
                        wr.id_en = 1'b1;
                        wr.slot  = r_count[stle_pkg::IDX_W-1:0];
                        wr.id    = i_session_id;
                        wr.stamp = i_now;
                        n_count  = r_count + stle_pkg::CNT_W'(1);
                        n_res.matched  = 1'b1;
                        n_res.slot     = r_count[stle_pkg::IDX_W-1:0];
                        n_res.replaced = 1'b0;
                        n_state  = stle_pkg::S_FINISH;
                    end else begin
                        n_start = 1'b1;
                        n_state = stle_pkg::S_SCAN;
                    end
                end
            end
            stle_pkg::S_SCAN: begin
                if (chain[MAX_ENTRIES].valid) begin
                    wr.id    = r_key;
                    wr.stamp = r_now;
                    if (r_action == stle_pkg::ACT_LOOKUP) begin
                        wr.en    = chain[MAX_ENTRIES].hit;
                        wr.id_en = 1'b0;
                        wr.slot  = chain[MAX_ENTRIES].hit_idx;
                        n_res.matched  = chain[MAX_ENTRIES].hit;
                        n_res.slot     = chain[MAX_ENTRIES].hit ?
                                         chain[MAX_ENTRIES].hit_idx : '0;
                        n_res.replaced = 1'b0;
                    end else begin
                        wr.en    = 1'b1;
                        wr.id_en = 1'b1;
                        wr.slot  = chain[MAX_ENTRIES].best_idx;
                        n_res.matched  = 1'b1;
                        n_res.slot     = chain[MAX_ENTRIES].best_idx;
                        n_res.replaced = 1'b1;
                    end
                    n_state = stle_pkg::S_FINISH;
                end
            end
            stle_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = stle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stle_pkg::S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stle_pkg::S_IDLE;
            r_count     <= '0;
            r_max       <= stle_pkg::CFG_W'(16);
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_start <= n_start;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Latch the item and the result words
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_action;
            r_key    <= i_session_id;
            r_now    <= i_now;
        end
        r_res <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    // Launch a fresh search record into the first cell
    always_comb begin
        chain[0]       = '0;
        chain[0].valid = r_start;
    end

    assign ctl.action = r_action;
    assign ctl.key    = r_key;
    assign ctl.count  = r_count;
    assign ctl.lim    = lim;

    // Row of slot cells
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        stle_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_wr    (wr),
            .i_probe (chain[g]),
            .o_probe (chain[g+1])
        );
    end

    assign o_out_valid       = r_out_valid;
    assign o_matched         = r_out.matched;
    assign o_slot            = r_out.slot[stle_pkg::SLOT_W-1:0];
    assign o_replaced_oldest = r_out.replaced;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stle_pkg::CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_probe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain[MAX_ENTRIES].valid |-> (r_state == stle_pkg::S_SCAN))
        else $error("search record finished outside a scan");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == stle_pkg::S_FINISH))
        else $error("result word loaded without a finished item");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != stle_pkg::S_IDLE))
        else $error("accepted item did not start work");
`endif

endmodule

@@ dv/session_table_lru_evict_test.sv @@
// Testbench for the session table with oldest-timestamp eviction: directed and random words.
module session_table_lru_evict_test;

    localparam int TABLE_SLOTS   = 16;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_ITEMS   = 104;
    localparam int SETTLE_CYCLES = TABLE_SLOTS + 6;
    localparam int POOL_SIZE     = 24;

    typedef struct packed {
        logic                         matched;
        logic [stle_pkg::SLOT_W-1:0]  slot;
        logic                         replaced;
    } t_session_outcome;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_action;
    logic [stle_pkg::ID_W-1:0]     i_session_id;
    logic [stle_pkg::TIME_W-1:0]   i_now;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic                          o_matched;
    logic [stle_pkg::SLOT_W-1:0]   o_slot;
    logic                          o_replaced_oldest;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [stle_pkg::CFG_W-1:0]    i_cfg_data;

    // Predicted table contents and register copy
    logic [stle_pkg::ID_W-1:0]     table_ids    [TABLE_SLOTS];
    logic [stle_pkg::TIME_W-1:0]   table_stamps [TABLE_SLOTS];
    int                            live_count;
    logic [stle_pkg::CFG_W-1:0]    max_reg;

    t_session_outcome              pending_outcomes [$];
    t_session_outcome              due_word;
    int unsigned                   fail_count = 0;
    logic                          steady;

    session_table_lru_evict #(
        .MAX_ENTRIES (TABLE_SLOTS)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_session_id      (i_session_id),
        .i_now             (i_now),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_matched         (o_matched),
        .o_slot            (o_slot),
        .o_replaced_oldest (o_replaced_oldest),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    // Free-running clock, period 20
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one word to the predicted table and return the outcome it should give
    function automatic t_session_outcome apply_session_word(
        input logic                        action,
        input logic [stle_pkg::ID_W-1:0]   id,
        input logic [stle_pkg::TIME_W-1:0] now
    );
        t_session_outcome res;
        int               lim;
        int               oldest;
        int               i;
        res = '0;
        lim = (max_reg == 0) ? 1 : ((max_reg > TABLE_SLOTS) ? TABLE_SLOTS : int'(max_reg));
        if (action == stle_pkg::ACT_CREATE) begin
            res.matched = 1'b1;
            if (live_count < lim) begin
                table_ids[live_count]    = id;
                table_stamps[live_count] = now;
                res.slot                 = 4'(live_count);
                live_count               = live_count + 1;
            end else begin
                // Oldest stamp among the first lim slots, lowest index on a tie
                oldest = 0;
                for (i = 1; i < lim; i++) begin
                    if (table_stamps[i] < table_stamps[oldest])
                        oldest = i;
                end
                table_ids[oldest]    = id;
                table_stamps[oldest] = now;
                res.slot             = 4'(oldest);
                res.replaced         = 1'b1;
            end
        end else begin
            // Lowest live slot with a matching identifier takes the new stamp
            for (i = 0; i < live_count && !res.matched; i++) begin
                if (table_ids[i] == id) begin
                    table_stamps[i] = now;
                    res.matched     = 1'b1;
                    res.slot        = 4'(i);
                end
            end
        end
        return res;
    endfunction

    // Drop valid for random cycles, then offer one word and hold it until taken
    task automatic send_session_word(
        input logic                        action,
        input logic [stle_pkg::ID_W-1:0]   id,
        input logic [stle_pkg::TIME_W-1:0] now
    );
        while (!steady && $urandom_range(99) < 38) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_action     <= action;
        i_session_id <= id;
        i_now        <= now;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_outcomes.insert(pending_outcomes.size(), apply_session_word(action, id, now));
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic wait_for_results;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the session limit while the block is idle
    task automatic write_session_limit(input logic [stle_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        max_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Empty table, appends, duplicates, hits and misses at the field extremes
    task automatic test_append_and_lookup;
        send_session_word(stle_pkg::ACT_LOOKUP, 64'h0, 32'h0);
        send_session_word(stle_pkg::ACT_CREATE, 64'h0, 32'hFFFF_FFFF);
        send_session_word(stle_pkg::ACT_CREATE, '1, 32'h0);
        send_session_word(stle_pkg::ACT_CREATE, 64'h0, 32'd5);
        send_session_word(stle_pkg::ACT_LOOKUP, 64'h0, 32'd9);
        send_session_word(stle_pkg::ACT_LOOKUP, '1, 32'hFFFF_FFFF);
        send_session_word(stle_pkg::ACT_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'd1);
        wait_for_results();
    endtask

    // Maximum below the count: evict among the first slots, ties to the lowest
    task automatic test_eviction_ties;
        write_session_limit(5'd2);
        send_session_word(stle_pkg::ACT_CREATE, 64'hA5A5_0000_0000_0001, 32'd9);
        send_session_word(stle_pkg::ACT_CREATE, 64'hA5A5_0000_0000_0002, 32'd9);
        send_session_word(stle_pkg::ACT_CREATE, 64'hA5A5_0000_0000_0003, 32'hFFFF_FFFF);
        send_session_word(stle_pkg::ACT_CREATE, 64'hA5A5_0000_0000_0004, 32'd3);
        // Entry past the maximum stays live
        send_session_word(stle_pkg::ACT_LOOKUP, 64'h0, 32'd4);
        wait_for_results();
    endtask

    // Register zero acts as one, register above the table acts as the table size
    task automatic test_register_extremes;
        write_session_limit(5'd0);
        send_session_word(stle_pkg::ACT_CREATE, 64'h5A5A_FFFF_0000_0001, 32'd1);
        send_session_word(stle_pkg::ACT_LOOKUP, '1, 32'd2);
        wait_for_results();
        write_session_limit(5'd31);
        send_session_word(stle_pkg::ACT_CREATE, 64'h5A5A_FFFF_0000_0002, 32'd6);
        send_session_word(stle_pkg::ACT_CREATE, '1, 32'd7);
        send_session_word(stle_pkg::ACT_LOOKUP, '1, 32'd8);
        wait_for_results();
    endtask

    // Phases of random creates and lookups over a pool of identifiers
    task automatic test_random_traffic;
        logic [stle_pkg::CFG_W-1:0]   settings [PHASE_COUNT];
        logic [stle_pkg::ID_W-1:0]    id_pool  [POOL_SIZE];
        logic [stle_pkg::TIME_W-1:0]  tick;
        logic [stle_pkg::TIME_W-1:0]  now;
        logic [stle_pkg::ID_W-1:0]    id;
        logic                         action;
        int                           p;
        int                           n;
        int                           k;
        int                           r;
        settings = '{5'd6, 5'd1, 5'd9, 5'd3, 5'd16, 5'd0,
                     5'd12, 5'd31, 5'd2, 5'd16, 5'd10, 5'd7};
        for (k = 0; k < POOL_SIZE; k++)
            id_pool[k] = {$urandom, $urandom};
        id_pool[0] = '0;
        id_pool[1] = '1;
        tick = 32'd100;
        for (p = 0; p < PHASE_COUNT; p++) begin
            wait_for_results();
            write_session_limit(settings[p]);
            // One phase runs with no gaps on either side
            steady = (p == 4);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                action = ($urandom_range(99) < 50) ? stle_pkg::ACT_CREATE : stle_pkg::ACT_LOOKUP;
                // Mostly a rising clock with ties, some stale and some arbitrary times
                r = $urandom_range(99);
                if (r < 75) begin
                    tick = tick + $urandom_range(3);
                    now  = tick;
                end else if (r < 90) begin
                    now = $urandom;
                end else begin
                    now = tick - $urandom_range(50);
                end
                if (action == stle_pkg::ACT_CREATE) begin
                    if ($urandom_range(99) < 60) begin
                        id = id_pool[$urandom_range(POOL_SIZE - 1)];
                    end else begin
                        id = {$urandom, $urandom};
                        id_pool[$urandom_range(POOL_SIZE - 1)] = id;
                    end
                end else begin
                    id = ($urandom_range(99) < 75) ? id_pool[$urandom_range(POOL_SIZE - 1)]
                                                   : {$urandom, $urandom};
                end
                send_session_word(action, id, now);
                if ($urandom_range(199) == 0)
                    wait_for_results();
            end
            steady = 1'b0;
        end
    endtask

    // Receiver stalls at random except in the steady stretch
    always @(negedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 38);
    end

    // Compare each taken result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result word: matched %0d slot %0d replaced %0d",
                         $time, o_matched, o_slot, o_replaced_oldest);
                fail_count++;
            end else begin
                due_word = pending_outcomes.pop_front();
                if (o_matched !== due_word.matched) begin
                    $display("%0t: matched mismatch: expected %0d, actual %0d",
                             $time, due_word.matched, o_matched);
                    fail_count++;
                end
                if (o_slot !== due_word.slot) begin
                    $display("%0t: slot mismatch: expected %0d, actual %0d",
                             $time, due_word.slot, o_slot);
                    fail_count++;
                end
                if (o_replaced_oldest !== due_word.replaced) begin
                    $display("%0t: replaced_oldest mismatch: expected %0d, actual %0d",
                             $time, due_word.replaced, o_replaced_oldest);
                    fail_count++;
                end
            end
        end
    end

    // Run the tests in turn
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_action     = stle_pkg::ACT_CREATE;
        i_session_id = '0;
        i_now        = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        steady       = 1'b0;
        live_count   = 0;
        max_reg      = 5'd16;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_append_and_lookup();
        test_eviction_ties();
        test_register_extremes();
        test_random_traffic();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("session_table_lru_evict regression: pass");
        else
            $display("session_table_lru_evict regression: fail");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #10_000_000;
        $display("session_table_lru_evict regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/stle_pkg.sv
rtl/stle_cell.sv
rtl/session_table_lru_evict.sv
dv/session_table_lru_evict_test.sv
